/* rtl/lph_pkg.sv */
`default_nettype none

package lph_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int MODE_W       = 2;
    localparam int KEY_W        = 31;
    localparam int SLOT_FIELD_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

/* rtl/lph_ram.sv */
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/lph_hash.sv */
`default_nettype none

module lph_hash #(
    parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lph_pkg::KEY_W-1:0]  key,
    output logic                            done,
    output logic      [$clog2(SLOTS)-1:0]   home
);

    import lph_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int NIB_N  = (KEY_W + 3) / 4;
    localparam int PAD_W  = NIB_N * 4;
    localparam int SUM_W  = ADDR_W + 3;
    localparam int TBL_W  = NIB_N * 16 * ADDR_W;

    // residue of every nibble value at every nibble position
    function automatic logic [TBL_W-1:0] residue_table();
        logic [TBL_W-1:0] t;
        int               p;
        t = '0;
        p = 1 % SLOTS;
        for (int j = 0; j < NIB_N; j++)
        begin
            for (int v = 0; v < 16; v++)
            begin
                t[(j * 16 + v) * ADDR_W +: ADDR_W] = ADDR_W'((v * p) % SLOTS);
            end
            p = (p * 16) % SLOTS;
        end
        return t;
    endfunction

    localparam logic [TBL_W-1:0] RES_TBL = residue_table();
    localparam logic [SUM_W-1:0] MOD_X1  = SUM_W'(SLOTS);
    localparam logic [SUM_W-1:0] MOD_X2  = SUM_W'(SLOTS * 2);
    localparam logic [SUM_W-1:0] MOD_X4  = SUM_W'(SLOTS * 4);

    logic [PAD_W-1:0]  key_pad;
    logic [SUM_W-1:0]  fold;
    logic [SUM_W-1:0]  fold_reg;
    logic              fold_vld_reg;
    logic [SUM_W-1:0]  red;
    logic              done_reg;
    logic [ADDR_W-1:0] rem_reg;
    logic [ADDR_W-1:0] rem_next;

    assign key_pad = PAD_W'(key);

    // sum of nibble residues stays below eight times the slot count
    always_comb
    begin
        fold = '0;
        for (int j = 0; j < NIB_N; j++)
        begin
            fold = fold + SUM_W'(RES_TBL[(j * 16 + int'(key_pad[j*4 +: 4])) * ADDR_W +: ADDR_W]);
        end
    end

    always_comb
    begin
        red = fold_reg;
        if (red >= MOD_X4)
        begin
            red = red - MOD_X4;
        end
        if (red >= MOD_X2)
        begin
            red = red - MOD_X2;
        end
        if (red >= MOD_X1)
        begin
            red = red - MOD_X1;
        end
        rem_next = red[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            fold_vld_reg <= start;
            done_reg     <= fold_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            fold_reg <= fold;
        end
        if (fold_vld_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_table.sv */
// channel  | signals                  | direction | notes
// ---------+--------------------------+-----------+---------------------------------
// request  | in_valid in_stall mode key  | in     | one word in flight at a time
// result   | out_valid out_stall status slot | out | one word per request, registered
//
// a request first forms its home slot (nibble residues summed and registered, then
// brought below SLOTS and registered), then probes the slot memory, one slot read a
// cycle, checking each slot of the ring at most once, and then hands over its result.
// after reset the slot memory is swept empty, one entry a cycle; in_stall stays
// high meanwhile.
// a stalled result is held in the output register; the next request is taken
// meanwhile and waits for it only at its own end.
`default_nettype none

module linear_probe_hash_table #(
    parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lph_pkg::MODE_W-1:0]        mode,
    input  wire logic [lph_pkg::KEY_W-1:0]         key,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   status,
    output logic      [lph_pkg::SLOT_FIELD_W-1:0]  slot
);

    import lph_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int WORD_W = KEY_W + 1;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SLOTS - 1);

    state_t st_reg;
    state_t st_next;

    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [ADDR_W-1:0]       addr_inc;
    logic [ADDR_W-1:0]       chk_addr_reg;
    logic [ADDR_W-1:0]       chk_cnt_reg;
    logic                    chk_vld_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [KEY_W-1:0]        key_reg;
    logic                    res_status_reg;
    logic [SLOT_FIELD_W-1:0] res_slot_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    status_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;

    logic                    hash_start;
    logic                    hash_done;
    logic [ADDR_W-1:0]       hash_home;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;

    logic                    rd_occ;
    logic [KEY_W-1:0]        rd_key;
    logic                    hit;
    logic                    term;
    logic                    accept;
    logic                    out_free;
    logic                    out_load;

    lph_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .home  (hash_home)
    );

    // each entry: occupied flag above the stored key
    lph_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_occ   = ram_rdata[KEY_W];
    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign addr_inc = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (st_reg == ST_RESULT) && out_free;

    always_comb
    begin
        hit = 1'b0;
        if (chk_vld_reg)
        begin
            if (mode_reg == MODE_INSERT)
            begin
                hit = !rd_occ;
            end
            else if (mode_reg == MODE_DELETE || mode_reg == MODE_SEARCH)
            begin
                hit = rd_occ && (rd_key == key_reg);
            end
        end
    end

    // stop on a hit or once every slot of the ring has been looked at
    assign term = chk_vld_reg && (hit || chk_cnt_reg == ADDR_LAST);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    st_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (term)
                begin
                    st_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        hash_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = chk_addr_reg;
        ram_wdata  = '0;
        ram_raddr  = addr_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                hash_start = in_valid;
            end
            ST_PROBE:
            begin
                if (term && hit && mode_reg == MODE_INSERT)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, key_reg};
                end
                else if (term && hit && mode_reg == MODE_DELETE)
                begin
                    ram_we = 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            clr_addr_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            chk_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            chk_vld_reg   <= (st_reg == ST_PROBE) && !term;
            if (st_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (st_reg != ST_PROBE)
            begin
                chk_cnt_reg <= '0;
            end
            else if (chk_vld_reg)
            begin
                chk_cnt_reg <= chk_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            key_reg  <= key;
        end
        if (hash_done)
        begin
            addr_reg <= hash_home;
        end
        else if (st_reg == ST_PROBE)
        begin
            addr_reg <= addr_inc;
        end
        chk_addr_reg <= addr_reg;
        if (term)
        begin
            res_status_reg <= !hit;
            res_slot_reg   <= hit ? SLOT_FIELD_W'(chk_addr_reg) : '0;
        end
        if (out_load)
        begin
            status_reg <= res_status_reg;
            slot_reg   <= res_slot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

endmodule

`default_nettype wire

/* rtl/lph_check.sv */
`default_nettype none

module lph_check (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [lph_pkg::MODE_W-1:0]        mode,
    input wire logic [lph_pkg::KEY_W-1:0]         key,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              status,
    input wire logic [lph_pkg::SLOT_FIELD_W-1:0]  slot
);

    // a stalled request word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(key))
        else $error("request word changed while stalled");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot))
        else $error("result word changed while stalled");

    // a miss or a full table always reports slot zero
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> slot == '0)
        else $error("slot not zero on failed request");

    // only one request in flight
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while another is in flight");

    // no result word appears out of an idle table
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> !$rose(out_valid))
        else $error("result word without a request");

endmodule

bind linear_probe_hash_table lph_check u_check (.*);

`default_nettype wire

/* bench/tb_linear_probe_hash_table.sv */
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

    import lph_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // idling phases
    localparam logic [1:0] PH_STEADY    = 2'd0;
    localparam logic [1:0] PH_TX_GAPS   = 2'd1;
    localparam logic [1:0] PH_RX_STALLS = 2'd2;
    localparam logic [1:0] PH_BOTH      = 2'd3;

    localparam int HOLD_AT     = 60;
    localparam int HOLD_LEN    = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int POOL        = 10;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [1:0]        phase;
        logic              drain;
    } request_t;

    typedef struct packed {
        logic                    status;
        logic [SLOT_FIELD_W-1:0] slot;
    } reply_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [MODE_W-1:0]       mode      = '0;
    logic [KEY_W-1:0]        key       = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    status;
    logic [SLOT_FIELD_W-1:0] slot;

    request_t request_backlog[$];
    reply_t   expected_replies[$];

    logic [KEY_W-1:0] table_keys [SLOTS];
    logic             table_used [SLOTS];

    logic [1:0] tx_phase       = PH_STEADY;
    int         requests_sent  = 0;
    int         replies_seen   = 0;
    int         failures       = 0;
    int         hold_left      = 0;
    bit         hold_done      = 1'b0;
    int         quiet_cycles   = 0;
    int         total_requests = 0;

    linear_probe_hash_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot      (slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // applies one request to the table copy and gives its reply
    function automatic reply_t probe_table(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k);
        reply_t r;
        int     s;
        int     found;
        r.status = 1'b1;
        r.slot   = '0;
        found    = -1;
        s        = int'(k % SLOTS);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (m == MODE_INSERT)
            begin
                if (!table_used[s])
                begin
                    found = s;
                    break;
                end
            end
            else if (table_used[s] && table_keys[s] == k)
            begin
                found = s;
                break;
            end
            s = (s + 1) % SLOTS;
        end
        if (m == MODE_UNUSED)
            found = -1;
        if (found >= 0)
        begin
            r.status = 1'b0;
            r.slot   = found[SLOT_FIELD_W-1:0];
            if (m == MODE_INSERT)
            begin
                table_used[found] = 1'b1;
                table_keys[found] = k;
            end
            else if (m == MODE_DELETE)
            begin
                table_used[found] = 1'b0;
                table_keys[found] = '0;
            end
        end
        return r;
    endfunction

    function automatic bit sender_idles(logic [1:0] ph);
        if (ph == PH_TX_GAPS)
            return $urandom_range(99) < 72;
        if (ph == PH_BOTH)
            return $urandom_range(99) < 17;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls(logic [1:0] ph);
        if (ph == PH_RX_STALLS)
            return $urandom_range(99) < 72;
        if (ph == PH_BOTH)
            return $urandom_range(99) < 17;
        return 1'b0;
    endfunction

    task automatic queue_request(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                 input logic [1:0] ph, input logic d);
        request_t q;
        q.mode  = m;
        q.key   = k;
        q.phase = ph;
        q.drain = d;
        request_backlog.push_back(q);
    endtask

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        logic     offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode     <= '0;
            key      <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                expected_replies.push_back(probe_table(mode, key));
                requests_sent++;
            end
            offer = 1'b0;
            // a drain-marked word waits until every reply is back
            if (request_backlog.size() != 0
                    && !(request_backlog[0].drain && expected_replies.size() != 0)
                    && !sender_idles(request_backlog[0].phase))
            begin
                nxt      = request_backlog.pop_front();
                offer    = 1'b1;
                mode     <= nxt.mode;
                key      <= nxt.key;
                tx_phase <= nxt.phase;
            end
            in_valid <= offer;
        end
    end

    // reply side
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected reply word: status %0d slot %0d", status, slot);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status || slot !== want.slot)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("reply %0d: expected status %0d slot %0d, got status %0d slot %0d",
                                     replies_seen, want.status, want.slot, status, slot);
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (replies_seen == HOLD_AT && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= receiver_stalls(tx_phase);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [KEY_W-1:0]  key_pool [POOL];
        logic [KEY_W-1:0]  k;
        logic [MODE_W-1:0] m;
        logic [1:0]        ph;
        int                insert_pct;
        int                delete_cut;
        int                r;

        rst_n = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            table_used[s] = 1'b0;
            table_keys[s] = '0;
        end

        // empty table, unused mode, wrap-round with a duplicate
        queue_request(MODE_SEARCH, '0, PH_STEADY, 1'b0);
        queue_request(MODE_UNUSED, '1, PH_STEADY, 1'b0);
        queue_request(MODE_INSERT, '0, PH_STEADY, 1'b0);
        queue_request(MODE_INSERT, '1, PH_STEADY, 1'b0);
        queue_request(MODE_INSERT, '1, PH_STEADY, 1'b0);
        queue_request(MODE_SEARCH, '1, PH_STEADY, 1'b0);
        queue_request(MODE_DELETE, '1, PH_STEADY, 1'b0);
        queue_request(MODE_SEARCH, '1, PH_STEADY, 1'b0);
        // fill every slot, then overflow and probe the full ring
        for (int i = 0; i < SLOTS - 2; i++)
            queue_request(MODE_INSERT, KEY_W'(i * SLOTS + 5), PH_STEADY, 1'b0);
        queue_request(MODE_INSERT, KEY_W'(32'h2AAA_AAA7), PH_STEADY, 1'b0);
        queue_request(MODE_SEARCH, KEY_W'(SLOTS * 40 + 5), PH_STEADY, 1'b0);
        queue_request(MODE_DELETE, KEY_W'(SLOTS * 41 + 5), PH_STEADY, 1'b0);
        queue_request(MODE_DELETE, KEY_W'(5), PH_STEADY, 1'b0);

        for (int seg = 0; seg < 8; seg++)
        begin
            ph = 2'(seg % 4);
            // keys crowd round the wrap point so probe chains cross it
            for (int j = 0; j < POOL; j++)
                key_pool[j] = {27'($urandom), 4'(($urandom_range(0, 5) + 13) % 16)};
            for (int i = 0; i < 78; i++)
            begin
                if (i % 39 == 0)
                begin
                    insert_pct = $urandom_range(15, 75);
                    delete_cut = insert_pct + (96 - insert_pct) / 2;
                end
                if ($urandom_range(99) < 80)
                    k = key_pool[$urandom_range(POOL - 1)];
                else
                    k = KEY_W'($urandom);
                r = $urandom_range(99);
                if (r < insert_pct)
                    m = MODE_INSERT;
                else if (r < delete_cut)
                    m = MODE_DELETE;
                else if (r < 96)
                    m = MODE_SEARCH;
                else
                    m = MODE_UNUSED;
                queue_request(m, k, ph, i == 0);
            end
        end
        total_requests = request_backlog.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (requests_sent == total_requests);
        wait (expected_replies.size() == 0);
        repeat (SLOTS + 11) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* linear_probe_hash_table.f */
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/lph_hash.sv
rtl/linear_probe_hash_table.sv
rtl/lph_check.sv
bench/tb_linear_probe_hash_table.sv
